// File: design/lifegen_pkg.sv
// Shared constants, types and next-generation logic for the life automaton block.
package lifegen_pkg;

  // Grid geometry
  localparam int GRID_WIDTH  = 8;
  localparam int GRID_HEIGHT = 32;
  localparam int ROW_AW      = $clog2(GRID_HEIGHT);

  // Stream field widths
  localparam int REQ_W       = 2;
  localparam int ROW_INDEX_W = 5;
  localparam int ROW_BITS_W  = 8;
  localparam int IN_DATA_W   = ((ROW_INDEX_W + ROW_BITS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((ROW_INDEX_W + ROW_BITS_W + 7) / 8) * 8;

  typedef logic [GRID_WIDTH-1:0] row_t;
  typedef logic [ROW_AW-1:0]     row_addr_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_STEP = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // write the incoming row
    logic prime;       // set up the row window for a generation
    logic start_read;  // rewind the row counter for a read run
    logic step_mode;   // read port looks one row ahead
    logic step_row;    // compute, store and emit one new row
    logic read_row;    // emit one stored row
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;    // output register can take an item this cycle
    logic last;        // row counter is on the final row
  } status_t;

  // Left neighbor of each column: bit j holds column j-1
  function automatic row_t left_of(row_t r, logic wrap);
    return {r[GRID_WIDTH-2:0], wrap & r[GRID_WIDTH-1]};
  endfunction

  // Right neighbor of each column: bit j holds column j+1
  function automatic row_t right_of(row_t r, logic wrap);
    return {wrap & r[0], r[GRID_WIDTH-1:1]};
  endfunction

  // B3/S23 rule applied to one row given its old neighbors above and below
  function automatic row_t next_row(row_t above, row_t mid, row_t below, logic wrap);
    row_t       res;
    row_t       a_l;
    row_t       a_r;
    row_t       m_l;
    row_t       m_r;
    row_t       b_l;
    row_t       b_r;
    logic [3:0] n;
    a_l = left_of(above, wrap);
    a_r = right_of(above, wrap);
    m_l = left_of(mid, wrap);
    m_r = right_of(mid, wrap);
    b_l = left_of(below, wrap);
    b_r = right_of(below, wrap);
    res = '0;
    for (int j = 0; j < GRID_WIDTH; j++) begin
      n = 4'(a_l[j]) + 4'(above[j]) + 4'(a_r[j]) + 4'(m_l[j]) + 4'(m_r[j])
        + 4'(b_l[j]) + 4'(below[j]) + 4'(b_r[j]);
      res[j] = (n == 4'd3) || (mid[j] && (n == 4'd2));
    end
    return res;
  endfunction

endpackage

// File: design/lifegen_ctrl.sv
// Request sequencer for the life automaton: accepts items and steps row runs.
module lifegen_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [lifegen_pkg::REQ_W-1:0]  req_type_i,
  output logic                           in_ready_o,
  input  lifegen_pkg::status_t           status_i,
  output lifegen_pkg::cmd_t              cmd_o
);
  import lifegen_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_READ
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Decode the request and drive the datapath
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_LOAD: cmd_o.load = 1'b1;
            REQ_STEP: begin
              cmd_o.prime = 1'b1;
              state_d     = ST_STEP;
            end
            REQ_READ: begin
              cmd_o.start_read = 1'b1;
              state_d          = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        cmd_o.step_mode = 1'b1;
        if (status_i.out_free) begin
          cmd_o.step_row = 1'b1;
          if (status_i.last) state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (status_i.out_free) begin
          cmd_o.read_row = 1'b1;
          if (status_i.last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/lifegen_datapath.sv
// Row store, three-row window, rule logic and output register of the life automaton.
module lifegen_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,
  input  logic [lifegen_pkg::ROW_INDEX_W-1:0]  in_row_index_i,
  input  logic [lifegen_pkg::ROW_BITS_W-1:0]   in_row_bits_i,
  input  lifegen_pkg::cmd_t                    cmd_i,
  output lifegen_pkg::status_t                 status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lifegen_pkg::ROW_INDEX_W-1:0]  out_row_index_o,
  output logic [lifegen_pkg::ROW_BITS_W-1:0]   out_row_bits_o,
  output logic                                 out_last_o
);
  import lifegen_pkg::*;

  logic                   wrap_q;
  row_t                   rows_q [GRID_HEIGHT];
  row_t                   above_q;
  row_t                   mid_q;
  row_t                   first_q;
  row_addr_t              cnt_q;
  row_addr_t              nxt_addr;
  row_addr_t              rd_addr;
  row_t                   rd_row;
  row_t                   below;
  row_t                   new_row;
  logic                   last;
  logic                   load_ok;
  logic                   out_valid_q;
  logic [ROW_INDEX_W-1:0] out_idx_q;
  logic [ROW_BITS_W-1:0]  out_bits_q;
  logic                   out_last_q;

  // Edge mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
    end else if (cfg_we_i) begin
      wrap_q <= cfg_wdata_i;
    end
  end

  // Row counter and single read port
  assign last     = (cnt_q == ROW_AW'(GRID_HEIGHT - 1));
  assign nxt_addr = last ? '0 : cnt_q + 1'b1;
  assign rd_addr  = cmd_i.step_mode ? nxt_addr : cnt_q;
  assign rd_row   = rows_q[rd_addr];

  // Row below the current one; at the bottom, the old first row with wrapping or dead cells without
  assign below   = last ? (wrap_q ? first_q : '0) : rd_row;
  assign new_row = next_row(above_q, mid_q, below, wrap_q);

  assign load_ok = (32'(in_row_index_i) < GRID_HEIGHT);

  // Grid store: loads and write-back of new rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GRID_HEIGHT; i++) rows_q[i] <= '0;
    end else if (cmd_i.load && load_ok) begin
      rows_q[ROW_AW'(in_row_index_i)] <= GRID_WIDTH'(in_row_bits_i);
    end else if (cmd_i.step_row) begin
      rows_q[cnt_q] <= new_row;
    end
  end

  // Window registers and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      above_q <= '0;
      mid_q   <= '0;
      first_q <= '0;
    end else if (cmd_i.prime) begin
      cnt_q   <= '0;
      above_q <= wrap_q ? rows_q[GRID_HEIGHT-1] : '0;
      mid_q   <= rows_q[0];
      first_q <= rows_q[0];
    end else if (cmd_i.start_read) begin
      cnt_q <= '0;
    end else if (cmd_i.step_row) begin
      cnt_q   <= nxt_addr;
      above_q <= mid_q;
      mid_q   <= below;
    end else if (cmd_i.read_row) begin
      cnt_q <= nxt_addr;
    end
  end

  // Output register: take a new item when empty or being drained
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last     = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step_row || cmd_i.read_row) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_row || cmd_i.read_row) begin
      out_idx_q  <= ROW_INDEX_W'(cnt_q);
      out_bits_q <= ROW_BITS_W'(cmd_i.step_row ? new_row : rd_row);
      out_last_q <= last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_index_o = out_idx_q;
  assign out_row_bits_o  = out_bits_q;
  assign out_last_o      = out_last_q;

`ifndef NO_ASSERTIONS
  // An emitted row never overwrites an item that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step_row || cmd_i.read_row) |-> (!out_valid_q || out_ready_i))
    else $error("row emitted while output register busy");

  // A generation starts at the top row
  a_prime_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prime |=> (cnt_q == '0))
    else $error("step run does not start at row zero");

  // Rows advance one at a time inside a run
  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.step_row || cmd_i.read_row) && !last) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("row counter skipped");

  // Loads and row emission never coincide
  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !(cmd_i.step_row || cmd_i.read_row || cmd_i.prime))
    else $error("load overlaps a run");
`endif

endmodule

// File: design/life_automaton_generation.sv
// Top level of the Game of Life (B3/S23) generation engine.
// The block keeps a grid of 32 rows of 8 one-bit cells, all dead after reset
// (no clearing pass is needed). Input items carry a request kind on s_axis_tuser:
// a load writes one row and gives no output; a read emits all 32 rows in order,
// tlast on the final one; a step computes one generation and emits the new rows
// the same way. A read or step emits one row per cycle through the single row
// read port and the rule logic, except while the output side stalls; no new item
// is accepted until the last row of a run has entered the output register.
// cfg_wdata_i selects toroidal edges (1) or dead cells outside the grid (0); write
// it only while the block is idle.
module life_automaton_generation (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_wdata_i,     // wrap_edges
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [4:0] row_index, [12:5] row_bits, [15:13] zero
  input  logic [lifegen_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] req_type
  input  logic [lifegen_pkg::REQ_W-1:0]         s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [4:0] out_row_index, [12:5] out_row_bits, [15:13] zero
  output logic [lifegen_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                                  m_axis_tlast     // last_row
);
  import lifegen_pkg::*;

  cmd_t                   cmd;
  status_t                status;
  logic [ROW_INDEX_W-1:0] out_idx;
  logic [ROW_BITS_W-1:0]  out_bits;

  lifegen_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .req_type_i (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lifegen_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_row_index_i  (s_axis_tdata[ROW_INDEX_W-1:0]),
    .in_row_bits_i   (s_axis_tdata[ROW_INDEX_W+ROW_BITS_W-1:ROW_INDEX_W]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_row_index_o (out_idx),
    .out_row_bits_o  (out_bits),
    .out_last_o      (m_axis_tlast)
  );

  // Pack the output item, padded with zeros to whole bytes
  assign m_axis_tdata = OUT_DATA_W'({out_bits, out_idx});

endmodule

// File: verif/tb.sv
// Self-checking testbench for the life automaton generation engine.
`timescale 1ns / 1ps

module tb;
  import lifegen_pkg::*;

  // Request code with no meaning to the block
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Rule constants: a dead cell with three live neighbors is born,
  // a live cell with two or three survives
  localparam int BIRTH_NEIGHBORS = 3;
  localparam int KEEP_NEIGHBORS  = 2;

  // Cycles for a run in flight to drain
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_AFTER_ROWS = 1500;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic [REQ_W-1:0]       kind;
    logic [ROW_INDEX_W-1:0] row;
    logic [ROW_BITS_W-1:0]  bits;
  } req_item_t;

  typedef struct packed {
    logic [ROW_INDEX_W-1:0] row;
    logic [ROW_BITS_W-1:0]  bits;
    logic                   last;
  } grid_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_wdata_i   = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [REQ_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;

  // Predictor state
  row_t        life_grid [GRID_HEIGHT];
  bit          wrap_model = 1'b0;
  grid_row_t   exp_rows [$];

  // Stimulus state
  req_item_t   req_q [$];
  req_item_t   cur_item;
  grid_row_t   want;
  bit          idle_on = 1'b1;
  int          queued_items = 0;
  int          items_accepted = 0;
  int          steps_done = 0;
  int          reads_done = 0;
  int          rows_seen = 0;
  int          fails = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;

  life_automaton_generation DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Cell value with the border treated as dead or wrapped around
  function automatic int cell_at(row_t r, int col, bit wrap);
    if (wrap) begin
      col = (col + GRID_WIDTH) % GRID_WIDTH;
    end else if (col < 0 || col >= GRID_WIDTH) begin
      return 0;
    end
    return int'(r[col]);
  endfunction

  // New value of one row from the old rows above, at and below it
  function automatic row_t evolve_row(row_t above, row_t mid, row_t below, bit wrap);
    row_t nxt;
    int   n;
    nxt = '0;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      n = 0;
      for (int dc = -1; dc <= 1; dc++) begin
        n += cell_at(above, c + dc, wrap) + cell_at(below, c + dc, wrap);
        if (dc != 0) n += cell_at(mid, c + dc, wrap);
      end
      nxt[c] = (n == BIRTH_NEIGHBORS) || (mid[c] && n == KEEP_NEIGHBORS);
    end
    return nxt;
  endfunction

  // Queue one expected row per grid row, last flag on the final one
  task automatic queue_grid_rows();
    for (int i = 0; i < GRID_HEIGHT; i++) begin
      exp_rows.push_back('{row: ROW_INDEX_W'(i), bits: ROW_BITS_W'(life_grid[i]),
                           last: (i == GRID_HEIGHT - 1)});
    end
  endtask

  // Apply one accepted request to the grid copy and queue its rows
  task automatic predict_request(req_item_t it);
    row_t old_grid [GRID_HEIGHT];
    row_t above;
    row_t below;
    case (it.kind)
      REQ_LOAD: begin
        if (int'(it.row) < GRID_HEIGHT) life_grid[it.row] = it.bits[GRID_WIDTH-1:0];
      end
      REQ_STEP: begin
        old_grid = life_grid;
        for (int i = 0; i < GRID_HEIGHT; i++) begin
          if (i == 0) above = wrap_model ? old_grid[GRID_HEIGHT-1] : '0;
          else above = old_grid[i-1];
          if (i == GRID_HEIGHT - 1) below = wrap_model ? old_grid[0] : '0;
          else below = old_grid[i+1];
          life_grid[i] = evolve_row(above, old_grid[i], below, wrap_model);
        end
        steps_done++;
        queue_grid_rows();
      end
      REQ_READ: begin
        reads_done++;
        queue_grid_rows();
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, got_val);
      fails++;
    end
  endtask

  // Driver: offer pending items, with random gaps while idling is on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_request(cur_item);
        items_accepted++;
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur_item = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({cur_item.bits, cur_item.row});
        s_axis_tuser  <= cur_item.kind;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each row and drive ready with stalls and one long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rows_seen++;
        if (exp_rows.size() == 0) begin
          $display("%0t: unexpected row: expected none, actual index %0d bits %h last %b",
                   $time, m_axis_tdata[ROW_INDEX_W-1:0],
                   m_axis_tdata[ROW_INDEX_W +: ROW_BITS_W], m_axis_tlast);
          fails++;
        end else begin
          want = exp_rows.pop_front();
          check_field("row index", want.row, m_axis_tdata[ROW_INDEX_W-1:0]);
          check_field("row bits", want.bits, m_axis_tdata[ROW_INDEX_W +: ROW_BITS_W]);
          check_field("last row", want.last, m_axis_tlast);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && rows_seen >= HOLD_AFTER_ROWS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d rows still expected", $time, exp_rows.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic add_item(logic [REQ_W-1:0] kind, logic [ROW_INDEX_W-1:0] row,
                          logic [ROW_BITS_W-1:0] bits);
    req_q.push_back('{kind: kind, row: row, bits: bits});
    if (kind != REQ_UNUSED) queued_items++;
  endtask

  // Row contents of varied density
  function automatic row_t rand_row();
    case ($urandom_range(0, 3))
      0: return row_t'($urandom);
      1: return row_t'($urandom & $urandom);
      2: return row_t'($urandom | $urandom);
      default: return row_t'($urandom & $urandom & $urandom);
    endcase
  endfunction

  // Mostly load-then-step sequences, with some noise and bare reads
  task automatic queue_random(int count);
    int stop;
    int k;
    stop = queued_items + count;
    while (queued_items < stop) begin
      case ($urandom_range(0, 39))
        0, 1, 2: add_item(REQ_UNUSED, ROW_INDEX_W'($urandom), ROW_BITS_W'($urandom));
        3: begin
          for (int r = 0; r < GRID_HEIGHT; r++) add_item(REQ_LOAD, ROW_INDEX_W'(r), rand_row());
        end
        4, 5: add_item(REQ_READ, ROW_INDEX_W'($urandom), ROW_BITS_W'($urandom));
        6, 7: add_item(REQ_LOAD, ROW_INDEX_W'($urandom), ROW_BITS_W'($urandom));
        default: begin
          k = $urandom_range(1, 6);
          repeat (k) add_item(REQ_LOAD, ROW_INDEX_W'($urandom), rand_row());
          k = $urandom_range(1, 3);
          repeat (k) add_item(REQ_STEP, ROW_INDEX_W'($urandom), ROW_BITS_W'($urandom));
          if ($urandom_range(0, 2) == 0) begin
            add_item(REQ_READ, ROW_INDEX_W'($urandom), ROW_BITS_W'($urandom));
          end
        end
      endcase
    end
  endtask

  // Wait until all items are taken and all rows are back, then let it settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (req_q.size() != 0 || s_axis_tvalid || exp_rows.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_wrap(bit value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    wrap_model = value;
    @(negedge clk_i);
  endtask

  // Main sequence
  initial begin
    foreach (life_grid[i]) life_grid[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_wrap(1'b0);

    // Dead border: empty grid, edge rows, still life, oscillator, glider
    add_item(REQ_READ, 5'd0, 8'h00);
    add_item(REQ_STEP, 5'd31, 8'hFF);
    add_item(REQ_LOAD, 5'd0, 8'hFF);
    add_item(REQ_LOAD, 5'd31, 8'hFF);
    add_item(REQ_LOAD, 5'd1, 8'h81);
    add_item(REQ_LOAD, 5'd30, 8'h80);
    add_item(REQ_LOAD, 5'd15, 8'h00);
    add_item(REQ_LOAD, 5'd5, 8'h03);
    add_item(REQ_LOAD, 5'd6, 8'h03);
    add_item(REQ_LOAD, 5'd10, 8'h1C);
    add_item(REQ_LOAD, 5'd20, 8'h02);
    add_item(REQ_LOAD, 5'd21, 8'h04);
    add_item(REQ_LOAD, 5'd22, 8'h07);
    add_item(REQ_UNUSED, 5'd31, 8'hFF);
    add_item(REQ_READ, 5'd31, 8'hFF);
    add_item(REQ_STEP, 5'd0, 8'h00);
    add_item(REQ_STEP, 5'd0, 8'h00);
    add_item(REQ_READ, 5'd0, 8'h00);
    wait_idle();

    // Torus: cells that touch across the corners
    write_wrap(1'b1);
    add_item(REQ_STEP, 5'd0, 8'h00);
    add_item(REQ_LOAD, 5'd0, 8'h81);
    add_item(REQ_LOAD, 5'd31, 8'h80);
    add_item(REQ_UNUSED, 5'd0, 8'h00);
    add_item(REQ_STEP, 5'd0, 8'h00);
    add_item(REQ_READ, 5'd0, 8'h00);
    wait_idle();

    queue_random(110);
    wait_idle();
    write_wrap(1'b0);
    queue_random(110);
    wait_idle();
    write_wrap(1'b1);
    queue_random(110);
    wait_idle();

    // Last stretch at full rate on both sides
    idle_on = 1'b0;
    write_wrap(1'b0);
    queue_random(100);
    wait_idle();

    $display("covered %0d requests: %0d steps, %0d reads, %0d rows checked",
             items_accepted, steps_done, reads_done, rows_seen);
    $display("both edge modes used, long output hold applied: %0d", hold_done);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: life_automaton_generation.f
design/lifegen_pkg.sv
design/lifegen_ctrl.sv
design/lifegen_datapath.sv
design/life_automaton_generation.sv
verif/tb.sv
